// File: hw/rtl/wgm_pkg.sv
package wgm_pkg;

    // largest pattern the registers can hold
    localparam int PATTERN_MAX = 16;
    localparam int PAT_BYTES   = 16;

    // apb geometry: 64-bit registers at 8-byte strides
    localparam int ADDR_W = 5;
    localparam int DATA_W = 64;
    localparam int LEN_W  = 5;

    // wildcard codes
    localparam logic [7:0] STAR_CODE     = 8'h2A;
    localparam logic [7:0] QUESTION_CODE = 8'h3F;

    // register indexes (paddr[4:3])
    typedef enum logic [1:0] {
        REG_PAT_LOW  = 2'd0,
        REG_PAT_HIGH = 2'd1,
        REG_PAT_LEN  = 2'd2
    } t_reg_idx;

    // decoded pattern handed from the register block to the match logic
    typedef struct packed {
        logic [PAT_BYTES*8-1:0] bytes;
        logic [PAT_BYTES-1:0]   star;
        logic [PAT_BYTES-1:0]   quest;
        logic [PAT_BYTES-1:0]   used;
        logic [LEN_W-1:0]       len;
    } t_pat_info;

endpackage

// File: hw/rtl/wgm_cfg.sv
module wgm_cfg #(
    parameter int P_PATTERN_MAX = wgm_pkg::PATTERN_MAX
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [wgm_pkg::ADDR_W-1:0] paddr,
    input  logic [wgm_pkg::DATA_W-1:0] pwdata,
    output logic [wgm_pkg::DATA_W-1:0] prdata,
    output logic                       pready,
    output wgm_pkg::t_pat_info         o_pat
);

    logic [wgm_pkg::DATA_W-1:0] r_pat_low;
    logic [wgm_pkg::DATA_W-1:0] r_pat_high;
    logic [wgm_pkg::LEN_W-1:0]  r_pat_len;
    wgm_pkg::t_reg_idx          idx;
    logic                       wr_en;
    logic [wgm_pkg::LEN_W-1:0]  lim;
    logic [wgm_pkg::LEN_W-1:0]  eff;
    logic [wgm_pkg::PAT_BYTES*8-1:0] bytes;

    assign pready = 1'b1;
    assign idx    = wgm_pkg::t_reg_idx'(paddr[4:3]);
    assign wr_en  = psel && penable && pwrite && pready;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_low  <= '0;
            r_pat_high <= '0;
            r_pat_len  <= '0;
        end else if (wr_en) begin
            case (idx)
                wgm_pkg::REG_PAT_LOW:  r_pat_low  <= pwdata;
                wgm_pkg::REG_PAT_HIGH: r_pat_high <= pwdata;
                wgm_pkg::REG_PAT_LEN:  r_pat_len  <= pwdata[wgm_pkg::LEN_W-1:0];
                default: ;
            endcase
        end
    end

    // register reads
    always_comb begin
        case (idx)
            wgm_pkg::REG_PAT_LOW:  prdata = r_pat_low;
            wgm_pkg::REG_PAT_HIGH: prdata = r_pat_high;
            wgm_pkg::REG_PAT_LEN:  prdata = {{(wgm_pkg::DATA_W-wgm_pkg::LEN_W){1'b0}}, r_pat_len};
            default:               prdata = '0;
        endcase
    end

    assign bytes = {r_pat_high, r_pat_low};

    // effective length: clamp, then cut at the first zero byte
    always_comb begin
        lim = (r_pat_len > wgm_pkg::LEN_W'(P_PATTERN_MAX)) ?
              wgm_pkg::LEN_W'(P_PATTERN_MAX) : r_pat_len;
        eff = lim;
        for (int k = wgm_pkg::PAT_BYTES - 1; k >= 0; k--) begin
            if ((wgm_pkg::LEN_W'(k) < lim) && (bytes[8*k +: 8] == 8'h00)) begin
                eff = wgm_pkg::LEN_W'(k);
            end
        end
    end

    // per-position class masks
    always_comb begin
        o_pat.bytes = bytes;
        o_pat.len   = eff;
        for (int k = 0; k < wgm_pkg::PAT_BYTES; k++) begin
            o_pat.star[k]  = (bytes[8*k +: 8] == wgm_pkg::STAR_CODE);
            o_pat.quest[k] = (bytes[8*k +: 8] == wgm_pkg::QUESTION_CODE);
            o_pat.used[k]  = (wgm_pkg::LEN_W'(k) < eff);
        end
    end

endmodule

// File: hw/rtl/wgm_step.sv
module wgm_step #(
    parameter int P_PATTERN_MAX = wgm_pkg::PATTERN_MAX
) (
    input  wgm_pkg::t_pat_info   i_pat,
    input  logic                 i_at_start,
    input  logic [P_PATTERN_MAX:0] i_active,
    input  logic [7:0]           i_char,
    input  logic                 i_has,
    output logic [P_PATTERN_MAX:0] o_next,
    output logic                 o_matched
);

    logic [P_PATTERN_MAX:0] v_start;
    logic [P_PATTERN_MAX:0] v_cur;
    logic [P_PATTERN_MAX:0] v_nxt;
    logic [P_PATTERN_MAX:0] v_after;

    // a live star lets the position after it go live too
    function automatic logic [P_PATTERN_MAX:0] star_close(
        input logic [P_PATTERN_MAX:0] set,
        input wgm_pkg::t_pat_info     pat
    );
        logic [P_PATTERN_MAX:0] res;
        res = set;
        for (int i = 0; i < P_PATTERN_MAX; i++) begin
            if (res[i] && pat.used[i] && pat.star[i]) begin
                res[i+1] = 1'b1;
            end
        end
        return res;
    endfunction

    // closed set before the byte
    always_comb begin
        v_start = i_at_start ? {{P_PATTERN_MAX{1'b0}}, 1'b1} : i_active;
        v_cur   = star_close(v_start, i_pat);
    end

    // advance positions over one text byte
    always_comb begin
        v_nxt = '0;
        for (int i = 0; i < P_PATTERN_MAX; i++) begin
            if (v_cur[i] && i_pat.used[i]) begin
                if (i_pat.star[i]) begin
                    v_nxt[i] = 1'b1;
                end else if (i_pat.quest[i] || (i_pat.bytes[8*i +: 8] == i_char)) begin
                    v_nxt[i+1] = 1'b1;
                end
            end
        end
        v_after = star_close(v_nxt, i_pat);
        o_next  = i_has ? v_after : v_cur;
    end

    // whole pattern consumed
    always_comb begin
        o_matched = 1'b0;
        for (int j = 0; j <= P_PATTERN_MAX; j++) begin
            if (i_pat.len == wgm_pkg::LEN_W'(j)) begin
                o_matched = o_next[j];
            end
        end
    end

endmodule

// File: hw/rtl/wildcard_glob_matcher.sv
// channel   | dir | tdata                    | tuser        | tlast
// s (text)  | in  | [7:0] char_code          | [0] has_char | last
// m (match) | out | [0] matched, [7:1] zero  | -            | -
// apb       | io  | 0x00 pattern low, 0x08 pattern high, 0x10 pattern length
//
// one text byte per cycle unless a stalled result blocks input
// a result passes the input register and then the result register around one position update
// synchronous active-low reset clears the position set and both valid flags
// a stalled result blocks input only once the input register also holds a last item
module wildcard_glob_matcher #(
    parameter int P_PATTERN_MAX = wgm_pkg::PATTERN_MAX
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_s_tvalid,
    output logic                       o_s_tready,
    input  logic [7:0]                 i_s_tdata,   // [7:0] char_code
    input  logic [0:0]                 i_s_tuser,   // [0] has_char
    input  logic                       i_s_tlast,
    output logic                       o_m_tvalid,
    input  logic                       i_m_tready,
    output logic [7:0]                 o_m_tdata,   // [0] matched, [7:1] zero
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [wgm_pkg::ADDR_W-1:0] paddr,
    input  logic [wgm_pkg::DATA_W-1:0] pwdata,
    output logic [wgm_pkg::DATA_W-1:0] prdata,
    output logic                       pready
);

    wgm_pkg::t_pat_info pat;

    logic                   r_in_valid;
    logic [7:0]             r_in_char;
    logic                   r_in_has;
    logic                   r_in_last;
    logic                   r_at_start;
    logic [P_PATTERN_MAX:0] r_active;
    logic                   r_out_valid;
    logic                   r_out_matched;

    logic                   has_eff;
    logic                   adv;
    logic [P_PATTERN_MAX:0] n_active;
    logic                   n_matched;

    wgm_cfg #(.P_PATTERN_MAX(P_PATTERN_MAX)) u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_pat   (pat)
    );

    wgm_step #(.P_PATTERN_MAX(P_PATTERN_MAX)) u_step (
        .i_pat      (pat),
        .i_at_start (r_at_start),
        .i_active   (r_active),
        .i_char     (r_in_char),
        .i_has      (has_eff),
        .o_next     (n_active),
        .o_matched  (n_matched)
    );

    // handshake: registered item moves on unless its result has nowhere to go
    assign has_eff    = r_in_has && (r_in_char != 8'h00);
    assign adv        = r_in_valid && (!r_in_last || !r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || adv;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_char <= i_s_tdata;
            r_in_has  <= i_s_tuser[0];
            r_in_last <= i_s_tlast;
        end
    end

    // position state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_at_start <= 1'b1;
            r_active   <= '0;
        end else if (adv) begin
            if (r_in_last) begin
                r_at_start <= 1'b1;
                r_active   <= '0;
            end else if (has_eff) begin
                r_at_start <= 1'b0;
                r_active   <= n_active;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && r_in_last) begin
            r_out_matched <= n_matched;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {7'b0, r_out_matched};

endmodule

// File: hw/rtl/wgm_checker.sv
module wgm_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_s_tvalid,
    input logic       o_s_tready,
    input logic       i_s_tlast,
    input logic       o_m_tvalid,
    input logic       i_m_tready,
    input logic [7:0] o_m_tdata
);

    logic [1:0] r_pending;
    logic       in_last_xfer;
    logic       out_xfer;

    assign in_last_xfer = i_s_tvalid && o_s_tready && i_s_tlast;
    assign out_xfer     = o_m_tvalid && i_m_tready;

    // texts ended but not yet answered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
        end else if (in_last_xfer && !out_xfer) begin
            r_pending <= r_pending + 2'd1;
        end else if (out_xfer && !in_last_xfer) begin
            r_pending <= r_pending - 2'd1;
        end
    end

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("result changed while stalled");

    // every result answers an ended text
    a_no_extra: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_xfer |-> (r_pending != 2'd0) || in_last_xfer)
        else $error("result without a last transaction");

    // at most the input and result registers hold ended texts
    a_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pending <= 2'd2)
        else $error("too many unanswered texts");

    // with the result register empty the input side never stalls
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_tvalid |-> o_s_tready)
        else $error("input stalled with empty result register");

    // padding bits stay zero
    a_pad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> o_m_tdata[7:1] == 7'd0)
        else $error("nonzero padding in result");

endmodule

bind wildcard_glob_matcher wgm_checker u_wgm_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .i_s_tlast  (i_s_tlast),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);

// File: test/glob_match_checker.sv
`timescale 1ns / 100ps

// watches the text, match and register channels, tracks the reachable
// pattern positions and compares every match result in order
module glob_match_checker
    import wgm_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    input  logic              i_s_tready,
    input  logic [7:0]        i_s_tdata,   // [7:0] char_code
    input  logic [0:0]        i_s_tuser,   // [0] has_char
    input  logic              i_s_tlast,
    input  logic              i_m_tvalid,
    input  logic              i_m_tready,
    input  logic [7:0]        i_m_tdata,   // [0] matched, [7:1] zero
    input  logic              i_psel,
    input  logic              i_penable,
    input  logic              i_pwrite,
    input  logic              i_pready,
    input  logic [ADDR_W-1:0] i_paddr,
    input  logic [DATA_W-1:0] i_pwdata,
    output int                o_fail_count,
    output int                o_pending,
    output int                o_result_count,
    output int                o_match_count
);

    // shadow copy of the pattern registers
    logic [63:0]        pat_low_q;
    logic [63:0]        pat_high_q;
    logic [LEN_W-1:0]   pat_len_q;

    // text progress: fresh text flag and set of matched pattern prefixes
    logic               fresh_text;
    logic [PATTERN_MAX:0] reach_set;

    // match verdicts waiting for their transaction on the output side
    logic               match_q[$];
    int                 fails;
    int                 results;
    int                 match_total;

    function automatic logic [7:0] pat_at(input int k);
        if (k < 8) begin
            return pat_low_q[8*k +: 8];
        end else if (k < 16) begin
            return pat_high_q[8*(k-8) +: 8];
        end
        return 8'h00;
    endfunction

    // clamp the length and stop at the first zero byte
    function automatic int live_len();
        int lim;
        lim = (int'(pat_len_q) > PATTERN_MAX) ? PATTERN_MAX : int'(pat_len_q);
        for (int k = 0; k < lim; k++) begin
            if (pat_at(k) == 8'h00) begin
                return k;
            end
        end
        return lim;
    endfunction

    // a reached star also reaches the position right after it
    function automatic logic [PATTERN_MAX:0] close_stars(input logic [PATTERN_MAX:0] s,
                                                         input int n);
        logic [PATTERN_MAX:0] r;
        r = s;
        for (int i = 0; i < n; i++) begin
            if (r[i] && pat_at(i) == STAR_CODE) begin
                r[i+1] = 1'b1;
            end
        end
        return r;
    endfunction

    // advance the position set by one accepted text transaction
    task automatic take_text_item(input logic [7:0] code, input logic has_bit,
                                  input logic end_bit);
        int                   n;
        logic                 has;
        logic [7:0]           p;
        logic [PATTERN_MAX:0] cur;
        logic [PATTERN_MAX:0] nxt;
        has = has_bit && (code != 8'h00);
        n   = live_len();
        if (has || end_bit) begin
            cur = close_stars(fresh_text ? (PATTERN_MAX+1)'(1) : reach_set, n);
            if (has) begin
                nxt = '0;
                for (int i = 0; i < n; i++) begin
                    if (cur[i]) begin
                        p = pat_at(i);
                        if (p == STAR_CODE) begin
                            nxt[i] = 1'b1;
                        end else if (p == QUESTION_CODE || p == code) begin
                            nxt[i+1] = 1'b1;
                        end
                    end
                end
                cur        = close_stars(nxt, n);
                fresh_text = 1'b0;
            end
            reach_set = cur;
            if (end_bit) begin
                match_q.push_back(cur[n]);
                fresh_text = 1'b1;
                reach_set  = '0;
            end
        end
    endtask

    // compare one match transaction with the oldest verdict
    task automatic check_result(input logic [7:0] data);
        logic want;
        if (match_q.size() == 0) begin
            $display("%0t: match result with none expected, actual %0b", $time, data[0]);
            fails++;
        end else begin
            want = match_q.pop_front();
            results++;
            if (data[0]) begin
                match_total++;
            end
            if (data[0] !== want) begin
                $display("%0t: matched expected %0b actual %0b", $time, want, data[0]);
                fails++;
            end
            if (data[7:1] !== 7'd0) begin
                $display("%0t: tdata padding expected 0 actual %h", $time, data[7:1]);
                fails++;
            end
        end
    endtask

    // sample all channels at the clock edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pat_low_q  = '0;
            pat_high_q = '0;
            pat_len_q  = '0;
            fresh_text = 1'b1;
            reach_set  = '0;
            match_q.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (i_paddr[4:3])
                    REG_PAT_LOW: begin
                        pat_low_q = i_pwdata[63:0];
                    end
                    REG_PAT_HIGH: begin
                        pat_high_q = i_pwdata[63:0];
                    end
                    REG_PAT_LEN: begin
                        pat_len_q = i_pwdata[LEN_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end
            if (i_s_tvalid && i_s_tready) begin
                take_text_item(i_s_tdata, i_s_tuser[0], i_s_tlast);
            end
            if (i_m_tvalid && i_m_tready) begin
                check_result(i_m_tdata);
            end
        end
        o_fail_count   <= fails;
        o_pending      <= match_q.size();
        o_result_count <= results;
        o_match_count  <= match_total;
    end

endmodule

// File: test/tb_wildcard_glob_matcher.sv
`timescale 1ns / 100ps

module tb_wildcard_glob_matcher;
    import wgm_pkg::*;

    localparam int WATCHDOG_LIMIT  = 3000;
    localparam int SETTLE_CYCLES   = 6;
    localparam int HOLD_OFF_CYCLES = 120;

    typedef logic [7:0] t_text[$];

    logic              i_clk    = 1'b0;
    logic              i_rst_n  = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [7:0]        s_tdata  = 8'h00;   // [7:0] char_code
    logic [0:0]        s_tuser  = 1'b0;    // [0] has_char
    logic              s_tlast  = 1'b0;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [7:0]        m_tdata;            // [0] matched, [7:1] zero
    logic              psel     = 1'b0;
    logic              penable  = 1'b0;
    logic              pwrite   = 1'b0;
    logic [ADDR_W-1:0] paddr    = '0;
    logic [DATA_W-1:0] pwdata   = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    int fail_count;
    int pending;
    int result_count;
    int match_count;

    int send_idle    = 0;
    int recv_idle    = 0;
    int hold_token   = 0;
    int items_sent   = 0;
    int texts_sent   = 0;
    int patterns_set = 0;
    int stall_cycles = 0;

    wildcard_glob_matcher DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .i_s_tlast  (s_tlast),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    glob_match_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_tvalid     (s_tvalid),
        .i_s_tready     (s_tready),
        .i_s_tdata      (s_tdata),
        .i_s_tuser      (s_tuser),
        .i_s_tlast      (s_tlast),
        .i_m_tvalid     (m_tvalid),
        .i_m_tready     (m_tready),
        .i_m_tdata      (m_tdata),
        .i_psel         (psel),
        .i_penable      (penable),
        .i_pwrite       (pwrite),
        .i_pready       (pready),
        .i_paddr        (paddr),
        .i_pwdata       (pwdata),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_result_count (result_count),
        .o_match_count  (match_count)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // receiver: random stalls, plus a long hold-off on request
    int hold_seen = 0;
    int hold_left = 0;
    always @(posedge i_clk) begin
        if (hold_token != hold_seen) begin
            hold_seen = hold_token;
            hold_left = HOLD_OFF_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_idle);
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge i_clk) begin
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, stall_cycles);
            $display("tb_wildcard_glob_matcher failed");
            $finish;
        end else if (!i_rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)
                     || (psel && penable && pwrite && pready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // one text transaction, with random idle cycles in front
    task automatic push_item(input logic [7:0] code, input logic has, input logic end_bit);
        while ($urandom_range(99) < send_idle) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= code;
        s_tuser  <= has;
        s_tlast  <= end_bit;
        @(posedge i_clk);
        while (!s_tready) begin
            @(posedge i_clk);
        end
        if ((has && code != 8'h00) || end_bit) begin
            items_sent++;
        end
    endtask

    // stop sending and wait until every verdict has come back
    task automatic quiesce();
        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // apb write: setup cycle then access cycle
    task automatic reg_write(input t_reg_idx idx, input logic [63:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic load_pattern(input logic [127:0] bits, input logic [4:0] n);
        quiesce();
        reg_write(REG_PAT_LOW, bits[63:0]);
        reg_write(REG_PAT_HIGH, bits[127:64]);
        reg_write(REG_PAT_LEN, 64'(n));
        patterns_set++;
    endtask

    function automatic logic [127:0] str_pat(input string s);
        logic [127:0] bits;
        bits = '0;
        for (int k = 0; k < s.len() && k < 16; k++) begin
            bits[8*k +: 8] = s[k];
        end
        return bits;
    endfunction

    function automatic t_text str_bytes(input string s);
        t_text txt;
        for (int k = 0; k < s.len(); k++) begin
            txt.push_back(s[k]);
        end
        return txt;
    endfunction

    // mostly a few letters, sometimes any nonzero byte
    function automatic logic [7:0] text_char();
        if ($urandom_range(99) < 85) begin
            return 8'h61 + 8'($urandom_range(2));
        end
        return 8'($urandom_range(1, 255));
    endfunction

    // send a text; noisy texts get empty items and zero bytes mixed in
    task automatic send_text(input t_text txt, input bit noisy);
        int n;
        bit split_end;
        n = txt.size();
        split_end = (n == 0) || (noisy && $urandom_range(99) < 30);
        for (int i = 0; i < n; i++) begin
            if (noisy && $urandom_range(99) < 8) begin
                push_item(8'($urandom_range(255)), 1'b0, 1'b0);
            end
            if (noisy && $urandom_range(99) < 4) begin
                push_item(8'h00, 1'b1, 1'b0);
            end
            push_item(txt[i], 1'b1, (i == n - 1) && !split_end);
        end
        if (split_end) begin
            if ($urandom_range(3) == 0) begin
                push_item(8'h00, 1'b1, 1'b1);
            end else begin
                push_item(8'($urandom_range(255)), 1'b0, 1'b1);
            end
        end
        texts_sent++;
    endtask

    // well-formed text for the pattern: stars and wildcards filled at random
    function automatic t_text expand_pattern(input logic [127:0] bits, input logic [4:0] n);
        t_text      txt;
        int         lim;
        logic [7:0] b;
        lim = (int'(n) > PATTERN_MAX) ? PATTERN_MAX : int'(n);
        for (int k = 0; k < lim; k++) begin
            b = bits[8*k +: 8];
            if (b == 8'h00) begin
                break;
            end
            if (b == STAR_CODE) begin
                repeat ($urandom_range(3)) txt.push_back(text_char());
            end else if (b == QUESTION_CODE) begin
                txt.push_back(text_char());
            end else begin
                txt.push_back(b);
            end
        end
        return txt;
    endfunction

    task automatic random_pattern(output logic [127:0] bits, output logic [4:0] n);
        int r;
        if ($urandom_range(99) < 4) begin
            bits = '1;
            n = $urandom_range(1) ? 5'd16 : 5'd31;
        end else begin
            for (int k = 0; k < 16; k++) begin
                r = $urandom_range(99);
                if (r < 40) begin
                    bits[8*k +: 8] = 8'h61 + 8'($urandom_range(2));
                end else if (r < 65) begin
                    bits[8*k +: 8] = STAR_CODE;
                end else if (r < 85) begin
                    bits[8*k +: 8] = QUESTION_CODE;
                end else if (r < 95) begin
                    bits[8*k +: 8] = 8'($urandom_range(1, 255));
                end else begin
                    bits[8*k +: 8] = 8'h00;
                end
            end
            r = $urandom_range(99);
            if (r < 80) begin
                n = 5'($urandom_range(6));
            end else if (r < 95) begin
                n = 5'($urandom_range(7, 16));
            end else begin
                n = 5'($urandom_range(17, 31));
            end
        end
    endtask

    task automatic random_text(input logic [127:0] bits, input logic [4:0] n,
                               output t_text txt);
        int         r;
        int         pos;
        logic [7:0] pick [5];
        pick = '{8'h61, 8'h62, 8'h63, STAR_CODE, QUESTION_CODE};
        txt.delete();
        r = $urandom_range(99);
        if (r < 60) begin
            txt = expand_pattern(bits, n);
            // broken copies: one character changed, dropped or added
            if ($urandom_range(99) < 30) begin
                pos = (txt.size() > 0) ? $urandom_range(txt.size() - 1) : 0;
                case ($urandom_range(2))
                    0: if (txt.size() > 0) txt[pos] = text_char();
                    1: if (txt.size() > 0) txt.delete(pos);
                    default: txt.insert(pos, text_char());
                endcase
            end
        end else if (r < 90) begin
            repeat ($urandom_range(8)) txt.push_back(pick[$urandom_range(4)]);
        end else begin
            repeat ($urandom_range(5)) txt.push_back(8'($urandom_range(1, 255)));
        end
    endtask

    task automatic run_directed();
        t_text none;
        // empty pattern
        load_pattern('0, 5'd0);
        send_text(none, 1'b0);
        send_text(str_bytes("x"), 1'b0);
        // pattern of stars only against the empty text
        load_pattern(str_pat("**"), 5'd2);
        send_text(none, 1'b0);
        // wildcard, high literal bytes, zero text byte and empty item mid text
        load_pattern(str_pat("a?") | (128'hFF << 16) | (128'(STAR_CODE) << 24), 5'd4);
        push_item(8'h61, 1'b1, 1'b0);
        push_item(8'h00, 1'b1, 1'b0);
        push_item(8'h5A, 1'b0, 1'b0);
        push_item(8'h51, 1'b1, 1'b0);
        push_item(8'hFF, 1'b1, 1'b0);
        push_item(8'h80, 1'b1, 1'b1);
        // zero pattern byte cuts the pattern short
        load_pattern(str_pat("ab") | (128'(STAR_CODE) << 24), 5'd4);
        send_text(str_bytes("ab"), 1'b0);
        send_text(str_bytes("abz"), 1'b0);
        // length above the limit: fifteen stars then a literal
        load_pattern({8'h71, {15{STAR_CODE}}}, 5'd31);
        send_text(str_bytes("r"), 1'b0);
        send_text(str_bytes("q"), 1'b0);
        // pattern rewritten while a text is open
        load_pattern(str_pat("a*"), 5'd2);
        push_item(8'h61, 1'b1, 1'b0);
        load_pattern(str_pat("abc"), 5'd3);
        push_item(8'h62, 1'b1, 1'b0);
        push_item(8'h63, 1'b1, 1'b1);
    endtask

    task automatic run_random(input int quota);
        int           target;
        logic [127:0] bits;
        logic [4:0]   n;
        t_text        txt;
        target = items_sent + quota;
        while (items_sent < target) begin
            random_pattern(bits, n);
            load_pattern(bits, n);
            repeat ($urandom_range(3, 8)) begin
                random_text(bits, n, txt);
                send_text(txt, 1'b1);
            end
        end
    endtask

    // stimulus and verdict
    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_idle = 38;
        recv_idle = 79;
        run_directed();
        run_random(150);

        send_idle = 79;
        recv_idle = 38;
        run_random(150);

        // receiver holds off while the sender keeps offering short texts
        send_idle = 0;
        recv_idle = 0;
        quiesce();
        hold_token++;
        repeat (12) push_item(8'h61 + 8'($urandom_range(2)), 1'b1, 1'b1);
        run_random(150);

        quiesce();
        $display("covered %0d text bytes in %0d strings over %0d pattern settings",
                 items_sent, texts_sent, patterns_set);
        $display("checked %0d match results, %0d of them matches", result_count, match_count);
        if (pending != 0) begin
            $display("%0d match results never arrived", pending);
        end
        if (fail_count == 0 && pending == 0) begin
            $display("tb_wildcard_glob_matcher passed");
        end else begin
            $display("tb_wildcard_glob_matcher failed");
        end
        $finish;
    end

endmodule

// File: wildcard_glob_matcher.f
hw/rtl/wgm_pkg.sv
hw/rtl/wgm_cfg.sv
hw/rtl/wgm_step.sv
hw/rtl/wildcard_glob_matcher.sv
hw/rtl/wgm_checker.sv
test/glob_match_checker.sv
test/tb_wildcard_glob_matcher.sv
